>>> rtl/zbpw_pkg.sv
package zbpw_pkg;

    localparam int MAX_SIDE   = 256;
    localparam int DEPTH_BITS = 32;

    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int STORE_SIZE = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [SIDE_W-1:0]     t_side;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [DEPTH_BITS-1:0] t_depth;
    typedef logic [31:0]           t_color;
    typedef logic [16:0]           t_bright;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = CFG_INDEX_W'(1);

    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam t_depth  FAR_DEPTH   = '1;
    localparam t_color  CLEAR_COLOR = 32'd255;
    localparam t_bright ONE_Q16     = 17'd65536;
    localparam t_side   SIDE_RESET  = SIDE_W'((MAX_SIDE < 256) ? MAX_SIDE : 256);
    localparam t_addr   INIT_LAST   = ADDR_W'(STORE_SIZE - 1);

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_READ,
        OP_CLEAR
    } t_op;

    // For a clear request, addr holds the last index in use.
    typedef struct packed {
        t_op    op;
        logic   on_screen;
        t_addr  addr;
        t_depth depth;
        t_color color;
    } t_job;

    typedef enum logic [1:0] {
        BS_INIT,
        BS_IDLE,
        BS_EXEC,
        BS_CLEAR
    } t_bstate;

    function automatic t_side clamp_side(input logic [CFG_DATA_W-1:0] v);
        t_side res;
        if (v == '0) begin
            res = t_side'(1);
        end else if (32'(v) > 32'(MAX_SIDE)) begin
            res = t_side'(MAX_SIDE);
        end else begin
            res = t_side'(v);
        end
        return res;
    endfunction

    // Round half up: (c * b + 0.5) in Q16, then drop the fraction.
    function automatic logic [7:0] shade_channel(input logic [7:0] c, input t_bright b);
        logic [24:0] prod;
        prod = 25'(c) * 25'(b) + 25'd32768;
        return prod[23:16];
    endfunction

endpackage

>>> rtl/zbpw_ifs.sv
interface zbpw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] depth;
    logic [31:0] color;
    logic [16:0] brightness;

    modport source (output valid, mode, x, y, depth, color, brightness, input ready);
    modport sink   (input valid, mode, x, y, depth, color, brightness, output ready);
endinterface

interface zbpw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_color;

    modport source (output valid, pixel_color, input ready);
    modport sink   (input valid, pixel_color, output ready);
endinterface

interface zbpw_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [8:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/zbuffer_pixel_writer.sv
// Draw and read requests each pass through the idle and execute states of the memory
// stage; a read waits there until the output register is free. A clear writes width*height
// entries, one entry per cycle through the single write port of the color and depth memories.
// Up to 4 requests queue between the front end and the memory stage.
// Reset is synchronous; afterwards a clearing pass fills every entry with color 255 and
// the far depth, and no request is accepted until it ends.
module zbuffer_pixel_writer import zbpw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    zbpw_in_if.sink    i_pix,
    zbpw_cfg_if.sink   i_cfg,
    zbpw_out_if.source o_pix
);

    logic push;
    t_job push_job;
    logic pop;
    logic q_full;
    logic q_empty;
    t_job head;
    logic init_busy;

    zbpw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg       (i_cfg),
        .i_init_busy (init_busy),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    zbpw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    zbpw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_pix       (o_pix)
    );

endmodule

>>> rtl/zbpw_front.sv
module zbpw_front import zbpw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    zbpw_in_if.sink    i_pix,
    zbpw_cfg_if.sink   i_cfg,
    input  logic       i_init_busy,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    localparam int CMP_W  = SIDE_W + 8;
    localparam int PROD_W = SIDE_W + 9;
    localparam int AREA_W = 2 * SIDE_W;

    t_side   r_width;
    t_side   r_height;
    logic    accept;
    logic    on_screen;
    t_bright bright;
    t_addr   pos;
    t_addr   clear_last;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIDE_RESET;
            r_height <= SIDE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_WIDTH:  r_width  <= clamp_side(i_cfg.data);
                REG_HEIGHT: r_height <= clamp_side(i_cfg.data);
                default: ;
            endcase
        end
    end

    assign i_pix.ready = !i_q_full && !i_init_busy;
    assign accept      = i_pix.valid && i_pix.ready;

    assign on_screen = (CMP_W'(i_pix.x) < CMP_W'(r_width)) &&
                       (CMP_W'(i_pix.y) < CMP_W'(r_height));
    assign pos    = t_addr'(PROD_W'(i_pix.x) * PROD_W'(r_height) + PROD_W'(i_pix.y));
    assign clear_last = t_addr'(AREA_W'(r_width) * AREA_W'(r_height) - AREA_W'(1));
    assign bright = (i_pix.brightness > ONE_Q16) ? ONE_Q16 : i_pix.brightness;

    always_comb begin
        o_job.on_screen = on_screen;
        o_job.addr   = pos;
        o_job.depth  = t_depth'(i_pix.depth);
        o_job.color  = {shade_channel(i_pix.color[31:24], bright),
                        shade_channel(i_pix.color[23:16], bright),
                        shade_channel(i_pix.color[15:8], bright),
                        i_pix.color[7:0]};
        o_job.op     = OP_DRAW;
        o_push       = 1'b0;
        unique case (i_pix.mode)
            MODE_DRAW: begin
                // Draws off the screen have no effect and are dropped here.
                o_push = accept && on_screen;
            end
            MODE_READ: begin
                o_job.op = OP_READ;
                o_push   = accept;
            end
            MODE_CLEAR: begin
                o_job.op   = OP_CLEAR;
                o_job.addr = clear_last;
                o_push     = accept;
            end
            default: o_push = 1'b0;
        endcase
    end

endmodule

>>> rtl/zbpw_fifo.sv
module zbpw_fifo import zbpw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

>>> rtl/zbpw_back.sv
module zbpw_back import zbpw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_job       i_head,
    output logic       o_pop,
    output logic       o_init_busy,
    zbpw_out_if.source o_pix
);

    t_color  r_color_mem [STORE_SIZE];
    t_depth  r_depth_mem [STORE_SIZE];
    t_color  r_color_rd;
    t_depth  r_depth_rd;

    t_bstate r_state;
    t_bstate n_state;
    t_addr   r_cnt;
    t_addr   n_cnt;
    t_job    r_job;
    t_job    n_job;
    logic    r_out_valid;
    t_color  r_out_color;

    logic    we;
    t_addr   wr_addr;
    t_color  wr_color;
    t_depth  wr_depth;
    t_addr   rd_addr;
    logic    load_out;

    assign o_init_busy       = (r_state == BS_INIT);
    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_color = r_out_color;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_color_mem[wr_addr] <= wr_color;
            r_depth_mem[wr_addr] <= wr_depth;
        end
        r_color_rd <= r_color_mem[rd_addr];
        r_depth_rd <= r_depth_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_job <= n_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_out_color <= r_job.on_screen ? r_color_rd : CLEAR_COLOR;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_job    = r_job;
        o_pop    = 1'b0;
        we       = 1'b0;
        wr_addr  = r_cnt;
        wr_color = CLEAR_COLOR;
        wr_depth = FAR_DEPTH;
        // Hold the address of the current request so a stalled read keeps its data.
        rd_addr  = (r_state == BS_IDLE) ? i_head.addr : r_job.addr;
        load_out = 1'b0;
        unique case (r_state)
            BS_INIT: begin
                we    = 1'b1;
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == INIT_LAST) begin
                    n_state = BS_IDLE;
                    n_cnt   = '0;
                end
            end
            BS_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_head;
                    n_cnt   = '0;
                    n_state = (i_head.op == OP_CLEAR) ? BS_CLEAR : BS_EXEC;
                end
            end
            BS_EXEC: begin
                unique case (r_job.op)
                    OP_DRAW: begin
                        if (r_job.depth < r_depth_rd) begin
                            we       = 1'b1;
                            wr_addr  = r_job.addr;
                            wr_color = r_job.color;
                            wr_depth = r_job.depth;
                        end
                        n_state = BS_IDLE;
                    end
                    OP_READ: begin
                        if (!r_out_valid || o_pix.ready) begin
                            load_out = 1'b1;
                            n_state  = BS_IDLE;
                        end
                    end
                    default: n_state = BS_IDLE;
                endcase
            end
            BS_CLEAR: begin
                we    = 1'b1;
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == r_job.addr) begin
                    n_state = BS_IDLE;
                    n_cnt   = '0;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_INIT) |-> !r_out_valid)
        else $error("result presented during the power-up clear");

    a_init_ends_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_INIT && r_cnt == INIT_LAST) |=> (r_state == BS_IDLE && r_cnt == '0))
        else $error("power-up clear did not finish at the last entry");

    a_clear_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_CLEAR) |-> (r_cnt <= r_job.addr))
        else $error("clear sweep ran past the entries in use");

    a_read_delivered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_EXEC && r_job.op == OP_READ && n_state == BS_IDLE) |=> r_out_valid)
        else $error("finished read request left no result");

endmodule

>>> sim/zbpw_checker.sv
`timescale 1ns / 1ps

module zbpw_checker import zbpw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    zbpw_in_if   pix,
    zbpw_cfg_if  cfg,
    zbpw_out_if  res,
    output int   o_fail_count,
    output int   o_pending
);

    t_color scr_color [STORE_SIZE];
    t_depth scr_depth [STORE_SIZE];
    t_side  scr_w;
    t_side  scr_h;
    t_color read_color_q [$];
    int     fails = 0;

    function automatic t_side fit_side(input logic [CFG_DATA_W-1:0] v);
        if (v == 0) begin
            return t_side'(1);
        end
        if (int'(v) > MAX_SIDE) begin
            return t_side'(MAX_SIDE);
        end
        return t_side'(v);
    endfunction

    function automatic logic [7:0] scale8(input logic [7:0] c, input t_bright b);
        logic [31:0] prod;
        prod = {24'd0, c} * {15'd0, b} + 32'd32768;
        return prod[23:16];
    endfunction

    // Brightness is already limited to one here; alpha passes through.
    function automatic t_color shade_rgb(input t_color c, input t_bright b);
        return {scale8(c[31:24], b), scale8(c[23:16], b), scale8(c[15:8], b), c[7:0]};
    endfunction

    task automatic wipe_in_use();
        int n;
        n = int'(scr_w) * int'(scr_h);
        for (int i = 0; i < n; i++) begin
            scr_color[i] = CLEAR_COLOR;
            scr_depth[i] = FAR_DEPTH;
        end
    endtask

    task automatic apply_request();
        logic    on_screen;
        int      pos;
        t_bright b;
        on_screen = (9'(pix.x) < scr_w) && (9'(pix.y) < scr_h);
        pos       = int'(pix.x) * int'(scr_h) + int'(pix.y);
        b         = (pix.brightness > ONE_Q16) ? ONE_Q16 : pix.brightness;
        case (pix.mode)
            MODE_DRAW: begin
                if (on_screen && (pix.depth < scr_depth[pos])) begin
                    scr_depth[pos] = pix.depth;
                    scr_color[pos] = shade_rgb(pix.color, b);
                end
            end
            MODE_READ: begin
                read_color_q.push_back(on_screen ? scr_color[pos] : CLEAR_COLOR);
            end
            MODE_CLEAR: begin
                wipe_in_use();
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        t_color want;
        if (read_color_q.size() == 0) begin
            fails++;
            $display("%0t: pixel_color with no read pending, expected none, actual %08h",
                     $time, res.pixel_color);
        end else begin
            want = read_color_q.pop_front();
            if (res.pixel_color !== want) begin
                fails++;
                $display("%0t: pixel_color mismatch, expected %08h, actual %08h",
                         $time, want, res.pixel_color);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scr_w = t_side'(MAX_SIDE);
            scr_h = t_side'(MAX_SIDE);
            for (int i = 0; i < STORE_SIZE; i++) begin
                scr_color[i] = CLEAR_COLOR;
                scr_depth[i] = FAR_DEPTH;
            end
            read_color_q.delete();
        end else begin
            // A result seen at this edge can only belong to an earlier read.
            if (res.valid && res.ready) begin
                check_result();
            end
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_WIDTH:  scr_w = fit_side(cfg.data);
                    REG_HEIGHT: scr_h = fit_side(cfg.data);
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready) begin
                apply_request();
            end
        end
        o_pending    <= read_color_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import zbpw_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [3:0] REG_UNUSED  = 4'd15;
    localparam int STALL_PCT   = 38;
    localparam int IDLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 123;

    logic i_clk;
    logic i_rst_n;

    zbpw_in_if  pix_if ();
    zbpw_cfg_if cfg_if ();
    zbpw_out_if res_if ();

    int fail_count;
    int pending;
    bit gaps_on  = 1'b1;
    int hold_req = 0;
    int stim_w   = 256;
    int stim_h   = 256;
    int idle_cycles = 0;

    logic [8:0] phase_w [PHASES] = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd1, 9'd256,
                                     9'd5, 9'd16, 9'd3, 9'd12, 9'd2, 9'd64};
    logic [8:0] phase_h [PHASES] = '{9'd1, 9'd0, 9'd256, 9'd300, 9'd256, 9'd1,
                                     9'd7, 9'd16, 9'd200, 9'd9, 9'd255, 9'd64};

    zbuffer_pixel_writer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_pix   (res_if)
    );

    zbpw_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pix          (pix_if),
        .cfg          (cfg_if),
        .res          (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (gaps_on) begin
                res_if.ready <= ($urandom_range(99) >= STALL_PCT);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (cfg_if.valid && cfg_if.ready) ||
            (res_if.valid && res_if.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("zbuffer_pixel_writer test failed");
            $finish;
        end
    end

    function automatic int eff_side(input logic [8:0] v);
        if (v == 0) begin
            return 1;
        end
        return (v > 256) ? 256 : int'(v);
    endfunction

    task automatic send_request(input logic [1:0] mode, input logic [7:0] x,
                                input logic [7:0] y, input logic [31:0] depth,
                                input logic [31:0] color, input logic [16:0] bright);
        bit took;
        while (gaps_on && ($urandom_range(99) < STALL_PCT)) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.mode       <= mode;
        pix_if.x          <= x;
        pix_if.y          <= y;
        pix_if.depth      <= depth;
        pix_if.color      <= color;
        pix_if.brightness <= bright;
        // Ready is stable from the falling edge until the next rising edge.
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = pix_if.ready;
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [8:0] val);
        bit took;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = cfg_if.ready;
            @(posedge i_clk);
        end
        cfg_if.valid <= 1'b0;
        if (idx == REG_WIDTH) begin
            stim_w = eff_side(val);
        end else if (idx == REG_HEIGHT) begin
            stim_h = eff_side(val);
        end
        @(posedge i_clk);
    endtask

    // A read is answered only after every earlier request, clears included, has finished.
    task automatic drain();
        send_request(MODE_READ, 8'd0, 8'd0, $urandom(), $urandom(), 17'd0);
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic rand_request();
        int         r;
        int         hot_x;
        int         hot_y;
        logic [1:0] mode;
        logic [7:0] x;
        logic [7:0] y;
        logic [31:0] depth;
        logic [16:0] bright;
        hot_x = (stim_w > 4) ? 3 : stim_w - 1;
        hot_y = (stim_h > 4) ? 3 : stim_h - 1;
        r = $urandom_range(99);
        if (r < 55) begin
            mode = MODE_DRAW;
        end else if (r < 93) begin
            mode = MODE_READ;
        end else if (r < 96) begin
            // Full-screen clears are far too slow to repeat at random.
            mode = (stim_w * stim_h <= 4096) ? MODE_CLEAR : MODE_READ;
        end else begin
            mode = MODE_UNUSED;
        end
        r = $urandom_range(99);
        if (r < 50) begin
            x = 8'($urandom_range(hot_x));
            y = 8'($urandom_range(hot_y));
        end else if (r < 85) begin
            x = 8'($urandom_range(stim_w - 1));
            y = 8'($urandom_range(stim_h - 1));
        end else begin
            x = 8'($urandom_range(255));
            y = 8'($urandom_range(255));
        end
        r = $urandom_range(99);
        if (r < 45) begin
            depth = $urandom_range(31);
        end else if (r < 55) begin
            depth = FAR_DEPTH;
        end else if (r < 65) begin
            depth = FAR_DEPTH - $urandom_range(3);
        end else begin
            depth = $urandom();
        end
        r = $urandom_range(99);
        if (r < 10) begin
            bright = ONE_Q16;
        end else if (r < 20) begin
            bright = 17'd0;
        end else if (r < 30) begin
            bright = 17'($urandom_range(131071, 65537));
        end else begin
            bright = 17'($urandom_range(65535));
        end
        send_request(mode, x, y, depth, $urandom(), bright);
    endtask

    // Stall the result side while reads keep coming, so the input backs up.
    task automatic squeeze();
        bit keep_gaps;
        keep_gaps = gaps_on;
        gaps_on   = 1'b0;
        hold_req  = HOLD_CYCLES;
        repeat (40) begin
            send_request(MODE_READ, 8'($urandom_range(3)), 8'($urandom_range(3)),
                         $urandom(), $urandom(), 17'($urandom_range(65535)));
        end
        gaps_on = keep_gaps;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        pix_if.valid      = 1'b0;
        pix_if.mode       = MODE_DRAW;
        pix_if.x          = 8'd0;
        pix_if.y          = 8'd0;
        pix_if.depth      = 32'd0;
        pix_if.color      = 32'd0;
        pix_if.brightness = 17'd0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = REG_WIDTH;
        cfg_if.data       = 9'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the full screen after reset.
        send_request(MODE_READ,  8'd0, 8'd0, 32'd0, 32'd0, 17'd0);
        send_request(MODE_DRAW,  8'd0, 8'd0, FAR_DEPTH, 32'hFFFF_FFFF, ONE_Q16);
        send_request(MODE_DRAW,  8'd0, 8'd0, 32'h8000_0000, 32'h1234_5678, ONE_Q16);
        send_request(MODE_DRAW,  8'd0, 8'd0, 32'h8000_0000, 32'hAAAA_AAAA, ONE_Q16);
        send_request(MODE_READ,  8'd0, 8'd0, 32'd0, 32'd0, 17'd0);
        send_request(MODE_DRAW,  8'd255, 8'd255, 32'd0, 32'hFFFF_FFFF, 17'h1FFFF);
        send_request(MODE_DRAW,  8'd1, 8'd2, 32'd5, 32'hFF80_017F, 17'd0);
        send_request(MODE_DRAW,  8'd1, 8'd3, 32'd5, 32'h80FF_01AA, 17'd32768);
        send_request(MODE_DRAW,  8'd1, 8'd4, 32'd5, 32'hC0FF_EE11, 17'd65537);
        send_request(MODE_READ,  8'd255, 8'd255, 32'd0, 32'd0, 17'd0);
        send_request(MODE_READ,  8'd1, 8'd2, 32'd0, 32'd0, 17'd0);
        send_request(MODE_READ,  8'd1, 8'd3, 32'd0, 32'd0, 17'd0);
        send_request(MODE_READ,  8'd1, 8'd4, 32'd0, 32'd0, 17'd0);
        send_request(MODE_UNUSED, 8'd255, 8'd255, 32'd0, 32'hFFFF_FFFF, ONE_Q16);
        send_request(MODE_CLEAR, 8'd0, 8'd0, 32'd0, 32'd0, 17'd0);
        send_request(MODE_READ,  8'd1, 8'd2, 32'd0, 32'd0, 17'd0);
        send_request(MODE_DRAW,  8'd255, 8'd255, 32'd1, 32'h55AA_55AA, 17'd40000);
        drain();

        // Small screen: off-screen requests, a different stride, a partial clear.
        write_reg(REG_UNUSED, 9'd1);
        write_reg(REG_WIDTH,  9'd3);
        write_reg(REG_HEIGHT, 9'd2);
        send_request(MODE_DRAW,  8'd3, 8'd0, 32'd0, 32'h0102_0304, ONE_Q16);
        send_request(MODE_DRAW,  8'd0, 8'd2, 32'd0, 32'h0102_0304, ONE_Q16);
        send_request(MODE_DRAW,  8'd1, 8'd1, 32'd7, 32'hDEAD_BEEF, 17'd50000);
        send_request(MODE_READ,  8'd1, 8'd1, 32'd0, 32'd0, 17'd0);
        send_request(MODE_READ,  8'd3, 8'd0, 32'd0, 32'd0, 17'd0);
        send_request(MODE_CLEAR, 8'd0, 8'd0, 32'd0, 32'd0, 17'd0);
        drain();
        write_reg(REG_WIDTH,  9'd256);
        write_reg(REG_HEIGHT, 9'd256);
        send_request(MODE_READ,  8'd255, 8'd255, 32'd0, 32'd0, 17'd0);
        send_request(MODE_READ,  8'd1, 8'd1, 32'd0, 32'd0, 17'd0);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_WIDTH,  phase_w[p]);
            write_reg(REG_HEIGHT, phase_h[p]);
            gaps_on = (p != 5);
            if (p == 7) begin
                squeeze();
            end
            repeat (PHASE_ITEMS) rand_request();
            drain();
        end
        gaps_on = 1'b1;

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("zbuffer_pixel_writer test passed");
        end else begin
            $display("zbuffer_pixel_writer test failed");
        end
        $finish;
    end

endmodule
